// ===== rtl/uep0_pkg.sv =====
package uep0_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 8;
  localparam int NumStr = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_MAX_PACKET_LOG2 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LANGUAGE_LEN    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAKER_LEN       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PRODUCT_LEN     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SERIAL_LEN      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_REPORT_LEN      = 3'd5;

  localparam logic [2:0] MPS_LOG2_MIN = 3'd3;
  localparam logic [2:0] MPS_LOG2_MAX = 3'd6;

  // descriptor sources
  localparam logic [2:0] SRC_NONE     = 3'd0;
  localparam logic [2:0] SRC_DEVICE   = 3'd1;
  localparam logic [2:0] SRC_CONFIG   = 3'd2;
  localparam logic [2:0] SRC_LANGUAGE = 3'd3;
  localparam logic [2:0] SRC_REPORT   = 3'd7;

  // outcome codes
  localparam logic [1:0] OUTCOME_DONE    = 2'd0;
  localparam logic [1:0] OUTCOME_IGNORED = 2'd1;
  localparam logic [1:0] OUTCOME_UNKNOWN = 2'd2;

  // bmRequestType type field
  localparam logic [1:0] TYPE_STANDARD = 2'd0;
  localparam logic [1:0] TYPE_CLASS    = 2'd1;
  localparam logic [1:0] TYPE_VENDOR   = 2'd2;

  // bRequest codes
  localparam logic [7:0] REQ_GET_STATUS        = 8'h00;
  localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'h01;
  localparam logic [7:0] REQ_SET_FEATURE       = 8'h03;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'h05;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
  localparam logic [7:0] REQ_SET_DESCRIPTOR    = 8'h07;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;
  localparam logic [7:0] REQ_GET_INTERFACE     = 8'h0a;
  localparam logic [7:0] REQ_SET_INTERFACE     = 8'h0b;
  localparam logic [7:0] REQ_SYNCH_FRAME       = 8'h0c;
  localparam logic [7:0] REQ_SET_IDLE          = 8'h0a;

  // descriptor types
  localparam logic [7:0] DESC_DEVICE = 8'h01;
  localparam logic [7:0] DESC_CONFIG = 8'h02;
  localparam logic [7:0] DESC_STRING = 8'h03;
  localparam logic [7:0] DESC_REPORT = 8'h22;

  localparam logic [7:0] DEVICE_DESC_LEN = 8'd18;

  typedef struct packed {
    logic [6:0]              mps;
    logic [NumStr-1:0][7:0]  str_len;
    logic [7:0]              report_len;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic       is_setup;
    logic [7:0] request_bits;
    logic [7:0] request_code;
    logic [7:0] value_low;
    logic [7:0] value_high;
    logic [7:0] length_low;
  } req_t;

  typedef struct packed {
    logic [7:0] remaining;
    logic [7:0] offset;
    logic [2:0] source;
    logic       zlp_due;
  } xfer_t;

  typedef struct packed {
    logic       setup_ack;
    logic       packet_send;
    logic [2:0] packet_source;
    logic [7:0] packet_offset;
    logic [6:0] packet_length;
    logic       address_write;
    logic [6:0] device_address;
    logic       endpoints_write;
    logic       endpoints_enable;
    logic [1:0] outcome;
  } result_t;

endpackage

// ===== rtl/uep0_cfg.sv =====
module uep0_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [uep0_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [uep0_pkg::CfgDataW-1:0]  cfg_data,
  output uep0_pkg::cfg_t                 cfg
);
  import uep0_pkg::*;

  logic [2:0] mps_log2;
  logic [7:0] language_len;
  logic [7:0] maker_len;
  logic [7:0] product_len;
  logic [7:0] serial_len;
  logic [7:0] report_len;
  logic [2:0] mps_log2_clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      mps_log2     <= 3'd4;
      language_len <= 8'd4;
      maker_len    <= 8'd52;
      product_len  <= 8'd28;
      serial_len   <= 8'd22;
      report_len   <= 8'd52;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAX_PACKET_LOG2: mps_log2     <= cfg_data[2:0];
        REG_LANGUAGE_LEN:    language_len <= cfg_data;
        REG_MAKER_LEN:       maker_len    <= cfg_data;
        REG_PRODUCT_LEN:     product_len  <= cfg_data;
        REG_SERIAL_LEN:      serial_len   <= cfg_data;
        REG_REPORT_LEN:      report_len   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (mps_log2 < MPS_LOG2_MIN) mps_log2_clamped = MPS_LOG2_MIN;
    else if (mps_log2 > MPS_LOG2_MAX)     mps_log2_clamped = MPS_LOG2_MAX;
    else                                   mps_log2_clamped = mps_log2;
  end

  assign cfg.mps        = 7'(7'd1 << mps_log2_clamped);
  assign cfg.str_len[0] = language_len;
  assign cfg.str_len[1] = maker_len;
  assign cfg.str_len[2] = product_len;
  assign cfg.str_len[3] = serial_len;
  assign cfg.report_len = report_len;

endmodule

// ===== rtl/uep0_decode.sv =====
module uep0_decode (
  input  uep0_pkg::cfg_t     cfg,
  input  uep0_pkg::req_t     req,
  input  uep0_pkg::xfer_t    xfer,
  output uep0_pkg::xfer_t    xfer_next,
  output uep0_pkg::result_t  res
);
  import uep0_pkg::*;

  typedef struct packed {
    xfer_t      st;
    logic       send;
    logic [2:0] source;
    logic [7:0] offset;
    logic [6:0] length;
  } chunk_t;

  function automatic chunk_t next_chunk(xfer_t s, logic [6:0] mps);
    chunk_t c;
    c = '0;
    c.st = s;
    priority if (s.remaining > {1'b0, mps}) begin
      c.send = 1'b1;
      c.source = s.source;
      c.offset = s.offset;
      c.length = mps;
      c.st.remaining = s.remaining - {1'b0, mps};
      c.st.offset = s.offset + {1'b0, mps};
    end else if (s.remaining != 8'd0) begin
      c.send = 1'b1;
      c.source = s.source;
      c.offset = s.offset;
      c.length = s.remaining[6:0];
      c.st.remaining = 8'd0;
    end else if (s.zlp_due) begin
      c.send = 1'b1;
      c.st.zlp_due = 1'b0;
    end
    return c;
  endfunction

  function automatic xfer_t start_reply(logic [2:0] src, logic [7:0] len,
                                        logic [7:0] want, logic [6:0] mps);
    xfer_t s;
    s.source = src;
    s.offset = 8'd0;
    if (want > len) begin
      s.remaining = len;
      s.zlp_due = (len & {1'b0, mps - 7'd1}) == 8'd0;
    end else begin
      s.remaining = want;
      s.zlp_due = 1'b0;
    end
    return s;
  endfunction

  localparam xfer_t STATUS_XFER = '{remaining: 8'd0, offset: 8'd0,
                                    source: SRC_NONE, zlp_due: 1'b1};

  logic [1:0] rtype;
  logic [1:0] code_outcome;
  xfer_t      started;
  chunk_t     chunk_in;
  chunk_t     chunk_go;
  logic       addr_wr;
  logic       ep_wr;

  assign rtype = req.request_bits[6:5];

  // setup decode: outcome and transfer state it starts
  always_comb begin
    code_outcome = OUTCOME_DONE;
    started = xfer;
    addr_wr = 1'b0;
    ep_wr = 1'b0;
    if (req.request_bits[7]) begin
      priority if (rtype == TYPE_CLASS || rtype == TYPE_VENDOR) begin
        code_outcome = OUTCOME_IGNORED;
      end else if (rtype != TYPE_STANDARD) begin
        code_outcome = OUTCOME_UNKNOWN;
      end else if (req.request_code == REQ_GET_CONFIGURATION ||
                   req.request_code == REQ_GET_INTERFACE ||
                   req.request_code == REQ_GET_STATUS ||
                   req.request_code == REQ_SYNCH_FRAME) begin
        code_outcome = OUTCOME_IGNORED;
      end else if (req.request_code != REQ_GET_DESCRIPTOR) begin
        code_outcome = OUTCOME_UNKNOWN;
      end else if (req.value_high == DESC_DEVICE) begin
        started = start_reply(SRC_DEVICE, DEVICE_DESC_LEN, req.length_low, cfg.mps);
      end else if (req.value_high == DESC_CONFIG) begin
        started = '{remaining: req.length_low, offset: 8'd0,
                    source: SRC_CONFIG, zlp_due: 1'b0};
      end else if (req.value_high == DESC_STRING) begin
        if (req.value_low < 8'(NumStr)) begin
          started = start_reply(SRC_LANGUAGE + {1'b0, req.value_low[1:0]},
                                cfg.str_len[req.value_low[1:0]],
                                req.length_low, cfg.mps);
        end else begin
          started = STATUS_XFER;
        end
      end else if (req.value_high == DESC_REPORT) begin
        started = start_reply(SRC_REPORT, cfg.report_len, req.length_low, cfg.mps);
      end else begin
        code_outcome = OUTCOME_UNKNOWN;
      end
    end else begin
      priority if (rtype == TYPE_VENDOR) begin
        code_outcome = OUTCOME_IGNORED;
      end else if (rtype == TYPE_CLASS) begin
        if (req.request_code == REQ_SET_IDLE) started = STATUS_XFER;
        else code_outcome = OUTCOME_UNKNOWN;
      end else if (rtype != TYPE_STANDARD) begin
        code_outcome = OUTCOME_UNKNOWN;
      end else if (req.request_code == REQ_CLEAR_FEATURE ||
                   req.request_code == REQ_SET_DESCRIPTOR ||
                   req.request_code == REQ_SET_FEATURE ||
                   req.request_code == REQ_SET_INTERFACE) begin
        code_outcome = OUTCOME_IGNORED;
      end else if (req.request_code == REQ_SET_ADDRESS) begin
        addr_wr = 1'b1;
        started = STATUS_XFER;
      end else if (req.request_code == REQ_SET_CONFIGURATION) begin
        ep_wr = 1'b1;
        started = STATUS_XFER;
      end else begin
        code_outcome = OUTCOME_UNKNOWN;
      end
    end
  end

  assign chunk_in = next_chunk(xfer, cfg.mps);
  assign chunk_go = next_chunk(started, cfg.mps);

  always_comb begin
    res = '0;
    xfer_next = xfer;
    priority if (req.req_type) begin
      res.packet_send   = chunk_in.send;
      res.packet_source = chunk_in.source;
      res.packet_offset = chunk_in.offset;
      res.packet_length = chunk_in.length;
      res.outcome       = chunk_in.send ? OUTCOME_DONE : OUTCOME_IGNORED;
      xfer_next         = chunk_in.st;
    end else if (!req.is_setup) begin
      res.outcome = OUTCOME_IGNORED;
    end else begin
      res.setup_ack = 1'b1;
      res.outcome = code_outcome;
      if (code_outcome == OUTCOME_DONE) begin
        res.packet_send      = chunk_go.send;
        res.packet_source    = chunk_go.source;
        res.packet_offset    = chunk_go.offset;
        res.packet_length    = chunk_go.length;
        res.address_write    = addr_wr;
        res.device_address   = addr_wr ? req.value_low[6:0] : 7'd0;
        res.endpoints_write  = ep_wr;
        res.endpoints_enable = ep_wr && (req.value_low != 8'd0);
        xfer_next            = chunk_go.st;
      end
    end
  end

endmodule

// ===== rtl/usb_ep0_request_responder_top.sv =====
// Endpoint zero control request responder.
// Input channel (in_valid/in_stall): one request per transfer event, either a
// packet received on endpoint zero OUT (setup or not) or an IN packet done.
// Output channel (out_valid/out_stall): exactly one result per request, with
// setup acknowledge, the next IN packet to load (descriptor source, offset,
// length, or a zero-length packet), device address / endpoint enable writes
// and an outcome code.
// Configuration port: cfg_write with cfg_index/cfg_data; the user must write
// it only while the block holds no request, which the block does not enforce;
// max packet size is log2, clamped to 8..64. A request is captured in the
// input register, then decoded into the result register that drives out_valid.
// Throughput: one request per cycle while out_stall is low; the transfer state
// updates with the decode, in the same cycle, so the next request sees it.
// When out_stall is held the result register holds its value and one more
// request may wait in the input register; in_stall rises when both are full.
// Reset clears both stages, the transfer state, and sets the configuration
// registers to their default values.
module usb_ep0_request_responder_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic                           is_setup,
  input  logic [7:0]                     request_bits,
  input  logic [7:0]                     request_code,
  input  logic [7:0]                     value_low,
  input  logic [7:0]                     value_high,
  input  logic [7:0]                     length_low,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           setup_ack,
  output logic                           packet_send,
  output logic [2:0]                     packet_source,
  output logic [7:0]                     packet_offset,
  output logic [6:0]                     packet_length,
  output logic                           address_write,
  output logic [6:0]                     device_address,
  output logic                           endpoints_write,
  output logic                           endpoints_enable,
  output logic [1:0]                     outcome,
  input  logic                           cfg_write,
  input  logic [uep0_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [uep0_pkg::CfgDataW-1:0]  cfg_data
);
  import uep0_pkg::*;

  cfg_t    cfg;
  req_t    req;
  logic    req_valid;
  xfer_t   xfer;
  xfer_t   xfer_next;
  result_t res;
  result_t res_next;
  logic    advance;

  uep0_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  uep0_decode u_decode (
    .cfg       (cfg),
    .req       (req),
    .xfer      (xfer),
    .xfer_next (xfer_next),
    .res       (res_next)
  );

  assign advance  = !out_valid || !out_stall;
  assign in_stall = req_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req <= '{req_type: req_type, is_setup: is_setup, request_bits: request_bits,
               request_code: request_code, value_low: value_low,
               value_high: value_high, length_low: length_low};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      xfer      <= '0;
    end else if (advance) begin
      out_valid <= req_valid;
      if (req_valid) xfer <= xfer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && req_valid) res <= res_next;
  end

  assign setup_ack        = res.setup_ack;
  assign packet_send      = res.packet_send;
  assign packet_source    = res.packet_source;
  assign packet_offset    = res.packet_offset;
  assign packet_length    = res.packet_length;
  assign address_write    = res.address_write;
  assign device_address   = res.device_address;
  assign endpoints_write  = res.endpoints_write;
  assign endpoints_enable = res.endpoints_enable;
  assign outcome          = res.outcome;

  // packets never exceed max packet size
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, packet_length} <= {1'b0, cfg.mps}))
    else $error("packet longer than max packet size");

  // zero-length or absent packet carries no source or offset
  assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_length == 7'd0 |->
      packet_source == SRC_NONE && packet_offset == 8'd0)
    else $error("empty packet with descriptor source");

  // register writes only on an acknowledged, acted-on setup
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (address_write || endpoints_write) |->
      setup_ack && outcome == OUTCOME_DONE && !(address_write && endpoints_write))
    else $error("register write without acted-on setup");

  // input stage only stalls while holding a request behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> req_valid && out_valid && out_stall)
    else $error("input stalled without backpressure");

  // transfer state moves only when a request is decoded
  assert property (@(posedge clk) disable iff (rst)
    !(req_valid && advance) |=> $stable(xfer))
    else $error("transfer state changed without a request");

endmodule

// ===== tb/sv/testbench.sv =====
import uep0_pkg::*;

class ep0_reply_tracker;
  logic [7:0] reg_val [6];
  logic [7:0] left_bytes;
  logic [7:0] next_offset;
  logic [2:0] reply_source;
  bit         zlp_pending;
  logic [7:0] config_value;
  result_t    pending_replies [$];
  int unsigned failures;

  function new();
    reg_val[REG_MAX_PACKET_LOG2] = 8'd4;
    reg_val[REG_LANGUAGE_LEN]    = 8'd4;
    reg_val[REG_MAKER_LEN]       = 8'd52;
    reg_val[REG_PRODUCT_LEN]     = 8'd28;
    reg_val[REG_SERIAL_LEN]      = 8'd22;
    reg_val[REG_REPORT_LEN]      = 8'd52;
    left_bytes   = '0;
    next_offset  = '0;
    reply_source = SRC_NONE;
    zlp_pending  = 1'b0;
    config_value = '0;
    failures     = 0;
  endfunction

  function void set_reg(logic [CfgIdxW-1:0] idx, logic [7:0] data);
    reg_val[idx] = (idx == REG_MAX_PACKET_LOG2) ? (data & 8'h07) : data;
  endfunction

  function int unsigned packet_size();
    int unsigned lg;
    lg = reg_val[REG_MAX_PACKET_LOG2];
    if (lg < MPS_LOG2_MIN) lg = MPS_LOG2_MIN;
    if (lg > MPS_LOG2_MAX) lg = MPS_LOG2_MAX;
    return 1 << lg;
  endfunction

  function bit transfer_open();
    return (left_bytes != 0) || zlp_pending;
  endfunction

  function int unsigned outstanding();
    return pending_replies.size();
  endfunction

  function bit next_packet(inout result_t r);
    int unsigned mp;
    mp = packet_size();
    if (left_bytes > mp) begin
      r.packet_send   = 1'b1;
      r.packet_source = reply_source;
      r.packet_offset = next_offset;
      r.packet_length = 7'(mp);
      left_bytes  = left_bytes - 8'(mp);
      next_offset = next_offset + 8'(mp);
      return 1'b1;
    end
    if (left_bytes != 0) begin
      r.packet_send   = 1'b1;
      r.packet_source = reply_source;
      r.packet_offset = next_offset;
      r.packet_length = 7'(left_bytes);
      left_bytes = '0;
      return 1'b1;
    end
    if (zlp_pending) begin
      r.packet_send = 1'b1;
      zlp_pending   = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void start_reply(logic [2:0] src, int unsigned len, int unsigned want);
    int unsigned mp;
    mp = packet_size();
    reply_source = src;
    next_offset  = '0;
    if (want > len) begin
      left_bytes  = 8'(len);
      zlp_pending = ((len & (mp - 1)) == 0);
    end else begin
      left_bytes  = 8'(want);
      zlp_pending = 1'b0;
    end
  endfunction

  function void start_status();
    reply_source = SRC_NONE;
    next_offset  = '0;
    left_bytes   = '0;
    zlp_pending  = 1'b1;
  endfunction

  function logic [1:0] decode_in(req_t q);
    logic [1:0] kind;
    kind = q.request_bits[6:5];
    if (kind == TYPE_CLASS || kind == TYPE_VENDOR) return OUTCOME_IGNORED;
    if (kind != TYPE_STANDARD) return OUTCOME_UNKNOWN;
    if (q.request_code == REQ_GET_CONFIGURATION || q.request_code == REQ_GET_INTERFACE ||
        q.request_code == REQ_GET_STATUS || q.request_code == REQ_SYNCH_FRAME)
      return OUTCOME_IGNORED;
    if (q.request_code != REQ_GET_DESCRIPTOR) return OUTCOME_UNKNOWN;
    case (q.value_high)
      DESC_DEVICE: start_reply(SRC_DEVICE, DEVICE_DESC_LEN, q.length_low);
      DESC_CONFIG: begin
        reply_source = SRC_CONFIG;
        next_offset  = '0;
        left_bytes   = q.length_low;
        zlp_pending  = 1'b0;
      end
      DESC_STRING: begin
        if (q.value_low < NumStr)
          start_reply(3'(SRC_LANGUAGE + q.value_low),
                      reg_val[REG_LANGUAGE_LEN + q.value_low], q.length_low);
        else
          start_status();
      end
      DESC_REPORT: start_reply(SRC_REPORT, reg_val[REG_REPORT_LEN], q.length_low);
      default: return OUTCOME_UNKNOWN;
    endcase
    return OUTCOME_DONE;
  endfunction

  function logic [1:0] decode_out(req_t q, inout result_t r);
    logic [1:0] kind;
    kind = q.request_bits[6:5];
    if (kind == TYPE_VENDOR) return OUTCOME_IGNORED;
    if (kind == TYPE_CLASS) begin
      if (q.request_code != REQ_SET_IDLE) return OUTCOME_UNKNOWN;
      start_status();
      return OUTCOME_DONE;
    end
    if (kind != TYPE_STANDARD) return OUTCOME_UNKNOWN;
    if (q.request_code == REQ_CLEAR_FEATURE || q.request_code == REQ_SET_DESCRIPTOR ||
        q.request_code == REQ_SET_FEATURE || q.request_code == REQ_SET_INTERFACE)
      return OUTCOME_IGNORED;
    if (q.request_code == REQ_SET_ADDRESS) begin
      r.address_write  = 1'b1;
      r.device_address = q.value_low[6:0];
      start_status();
      return OUTCOME_DONE;
    end
    if (q.request_code == REQ_SET_CONFIGURATION) begin
      config_value       = q.value_low;
      r.endpoints_write  = 1'b1;
      r.endpoints_enable = (q.value_low != 0);
      start_status();
      return OUTCOME_DONE;
    end
    return OUTCOME_UNKNOWN;
  endfunction

  function void note_request(req_t q);
    result_t r;
    bit      sent;
    r = '0;
    if (q.req_type) begin
      sent = next_packet(r);
      r.outcome = sent ? OUTCOME_DONE : OUTCOME_IGNORED;
    end else if (!q.is_setup) begin
      r.outcome = OUTCOME_IGNORED;
    end else begin
      r.setup_ack = 1'b1;
      if (q.request_bits[7]) r.outcome = decode_in(q);
      else r.outcome = decode_out(q, r);
      if (r.outcome == OUTCOME_DONE) sent = next_packet(r);
    end
    pending_replies.push_back(r);
  endfunction

  function void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  function void check_reply(result_t got);
    result_t exp;
    if (pending_replies.size() == 0) begin
      $error("result with no request outstanding");
      failures++;
      return;
    end
    exp = pending_replies.pop_front();
    check_field("setup_ack", exp.setup_ack, got.setup_ack);
    check_field("packet_send", exp.packet_send, got.packet_send);
    check_field("packet_source", exp.packet_source, got.packet_source);
    check_field("packet_offset", exp.packet_offset, got.packet_offset);
    check_field("packet_length", exp.packet_length, got.packet_length);
    check_field("address_write", exp.address_write, got.address_write);
    check_field("device_address", exp.device_address, got.device_address);
    check_field("endpoints_write", exp.endpoints_write, got.endpoints_write);
    check_field("endpoints_enable", exp.endpoints_enable, got.endpoints_enable);
    check_field("outcome", exp.outcome, got.outcome);
  endfunction
endclass

module testbench;
  localparam logic [1:0] TYPE_RESERVED = 2'd3;
  localparam int NUM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int HOLD_CYCLES = 64;
  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic req_type;
  logic is_setup;
  logic [7:0] request_bits;
  logic [7:0] request_code;
  logic [7:0] value_low;
  logic [7:0] value_high;
  logic [7:0] length_low;
  logic out_valid;
  logic out_stall;
  logic setup_ack;
  logic packet_send;
  logic [2:0] packet_source;
  logic [7:0] packet_offset;
  logic [6:0] packet_length;
  logic address_write;
  logic [6:0] device_address;
  logic endpoints_write;
  logic endpoints_enable;
  logic [1:0] outcome;
  logic cfg_write;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  result_t seen;
  ep0_reply_tracker tracker;
  int unsigned counted_items;
  int unsigned tx_gap_pct;
  int unsigned rx_stall_pct;
  int unsigned hold_requests;
  int unsigned holds_done;
  int unsigned quiet_cycles;

  usb_ep0_request_responder_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .is_setup(is_setup), .request_bits(request_bits),
    .request_code(request_code), .value_low(value_low), .value_high(value_high),
    .length_low(length_low),
    .out_valid(out_valid), .out_stall(out_stall),
    .setup_ack(setup_ack), .packet_send(packet_send), .packet_source(packet_source),
    .packet_offset(packet_offset), .packet_length(packet_length),
    .address_write(address_write), .device_address(device_address),
    .endpoints_write(endpoints_write), .endpoints_enable(endpoints_enable),
    .outcome(outcome),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  assign seen = {setup_ack, packet_send, packet_source, packet_offset, packet_length,
                 address_write, device_address, endpoints_write, endpoints_enable, outcome};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_reply(seen);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // receiver side: short random stalls, or a long hold-off on request
  initial begin
    int unsigned n;
    out_stall <= 1'b0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        holds_done++;
      end else if (rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct) begin
        n = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic req_t mk(logic rt, logic su, logic [7:0] bits, logic [7:0] code,
                              logic [7:0] vlo, logic [7:0] vhi, logic [7:0] len);
    req_t r;
    r.req_type     = rt;
    r.is_setup     = su;
    r.request_bits = bits;
    r.request_code = code;
    r.value_low    = vlo;
    r.value_high   = vhi;
    r.length_low   = len;
    return r;
  endfunction

  function automatic logic [7:0] req_bits(logic dir_in, logic [1:0] kind);
    return {dir_in, kind, 5'($urandom_range(0, 31))};
  endfunction

  function automatic req_t random_request();
    return mk(1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom));
  endfunction

  function automatic req_t in_done();
    req_t r;
    r = random_request();
    r.req_type = 1'b1;
    return r;
  endfunction

  task automatic send_request(input req_t r);
    int unsigned n;
    if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
      n = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= r.req_type;
    is_setup     <= r.is_setup;
    request_bits <= r.request_bits;
    request_code <= r.request_code;
    value_low    <= r.value_low;
    value_high   <= r.value_high;
    length_low   <= r.length_low;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(r);
    if (r.req_type || r.is_setup) counted_items++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.set_reg(idx, data);
  endtask

  task automatic program_phase(input int p);
    logic [7:0] vals [6];
    int unsigned mp;
    case (p)
      0: vals = '{8'd3, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
      1: vals = '{8'd6, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
      2: vals = '{8'd0, 8'd8, 8'd16, 8'd24, 8'd64, 8'd128};
      3: vals = '{8'd7, 8'd64, 8'd128, 8'd192, 8'd0, 8'd255};
      default: vals = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    endcase
    if (p > 3) begin
      write_reg(REG_MAX_PACKET_LOG2, 8'($urandom_range(0, 7)));
      mp = tracker.packet_size();
      for (int i = REG_LANGUAGE_LEN; i <= REG_REPORT_LEN; i++) begin
        if ($urandom_range(0, 1) == 0) write_reg(3'(i), 8'(mp * $urandom_range(0, 255 / mp)));
        else write_reg(3'(i), 8'($urandom_range(0, 255)));
      end
    end else begin
      for (int i = REG_MAX_PACKET_LOG2; i <= REG_REPORT_LEN; i++) write_reg(3'(i), vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic run_directed();
    req_t plan [$];
    plan.push_back(mk(1'b0, 1'b0, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    plan.push_back(mk(1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b1, TYPE_STANDARD), REQ_GET_DESCRIPTOR,
                      8'd0, DESC_DEVICE, 8'd255));
    plan.push_back(in_done());
    plan.push_back(in_done());
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b1, TYPE_STANDARD), REQ_GET_DESCRIPTOR,
                      8'd0, DESC_DEVICE, 8'd0));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b1, TYPE_STANDARD), REQ_GET_DESCRIPTOR,
                      8'd0, DESC_CONFIG, 8'd64));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b1, TYPE_STANDARD), REQ_GET_DESCRIPTOR,
                      8'd1, DESC_STRING, 8'd255));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b1, TYPE_STANDARD), REQ_GET_DESCRIPTOR,
                      8'd4, DESC_STRING, 8'd255));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b1, TYPE_STANDARD), REQ_GET_DESCRIPTOR,
                      8'd255, DESC_STRING, 8'd10));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b1, TYPE_STANDARD), REQ_GET_DESCRIPTOR,
                      8'd0, DESC_REPORT, 8'd52));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b1, TYPE_STANDARD), REQ_GET_DESCRIPTOR,
                      8'd0, 8'hff, 8'd20));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b1, TYPE_CLASS), REQ_CLEAR_FEATURE,
                      8'd0, 8'd0, 8'd8));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b1, TYPE_VENDOR), REQ_GET_DESCRIPTOR,
                      8'd0, DESC_DEVICE, 8'd8));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b1, TYPE_RESERVED), REQ_GET_DESCRIPTOR,
                      8'd0, DESC_DEVICE, 8'd8));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b1, TYPE_STANDARD), REQ_GET_STATUS,
                      8'd0, 8'd0, 8'd2));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b1, TYPE_STANDARD), 8'hff, 8'd0, 8'd0, 8'd2));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b0, TYPE_STANDARD), REQ_SET_ADDRESS,
                      8'hff, 8'h00, 8'h00));
    plan.push_back(in_done());
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b0, TYPE_STANDARD), REQ_SET_CONFIGURATION,
                      8'd0, 8'd0, 8'd0));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b0, TYPE_STANDARD), REQ_SET_CONFIGURATION,
                      8'd1, 8'd0, 8'd0));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b0, TYPE_CLASS), REQ_SET_IDLE, 8'd0, 8'd0, 8'd0));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b0, TYPE_CLASS), REQ_SET_CONFIGURATION,
                      8'd0, 8'd0, 8'd0));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b0, TYPE_VENDOR), REQ_SET_ADDRESS,
                      8'd5, 8'd0, 8'd0));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b0, TYPE_RESERVED), REQ_SET_ADDRESS,
                      8'd5, 8'd0, 8'd0));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b0, TYPE_STANDARD), REQ_CLEAR_FEATURE,
                      8'd0, 8'd0, 8'd0));
    plan.push_back(mk(1'b0, 1'b1, req_bits(1'b0, TYPE_STANDARD), 8'hff, 8'd0, 8'd0, 8'd0));
    foreach (plan[i]) send_request(plan[i]);
  endtask

  // a descriptor read or a status request followed by its IN packets,
  // sometimes cut short; otherwise noise
  task automatic run_sequence();
    req_t r;
    int unsigned pick, k, idx, len, want, mp, cut, n;
    pick = $urandom_range(0, 99);
    mp = tracker.packet_size();
    if (pick < 55) begin
      k = $urandom_range(0, 9);
      r = mk(1'b0, 1'b1, req_bits(1'b1, TYPE_STANDARD), REQ_GET_DESCRIPTOR, 8'($urandom),
             DESC_STRING, 8'd0);
      if (k < 2) begin
        r.value_high = DESC_DEVICE;
        len = DEVICE_DESC_LEN;
      end else if (k == 2) begin
        r.value_high = DESC_CONFIG;
        len = $urandom_range(0, 255);
      end else if (k < 7) begin
        idx = $urandom_range(0, NumStr - 1);
        r.value_low = 8'(idx);
        len = tracker.reg_val[REG_LANGUAGE_LEN + idx];
      end else if (k < 9) begin
        r.value_high = DESC_REPORT;
        len = tracker.reg_val[REG_REPORT_LEN];
      end else begin
        r.value_low = 8'($urandom_range(NumStr, 255));
        len = 0;
      end
      case ($urandom_range(0, 6))
        0: want = len;
        1: want = (len < 255) ? len + 1 : 255;
        2: want = (len > 0) ? len - 1 : 0;
        3: want = 255;
        4: want = 0;
        5: want = mp * $urandom_range(0, 255 / mp);
        default: want = $urandom_range(0, 255);
      endcase
      r.length_low = 8'(want);
      send_request(r);
    end else if (pick < 75) begin
      case ($urandom_range(0, 2))
        0: r = mk(1'b0, 1'b1, req_bits(1'b0, TYPE_STANDARD), REQ_SET_ADDRESS, 8'($urandom),
                  8'($urandom), 8'($urandom));
        1: r = mk(1'b0, 1'b1, req_bits(1'b0, TYPE_STANDARD), REQ_SET_CONFIGURATION,
                  ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom), 8'($urandom),
                  8'($urandom));
        default: r = mk(1'b0, 1'b1, req_bits(1'b0, TYPE_CLASS), REQ_SET_IDLE, 8'($urandom),
                        8'($urandom), 8'($urandom));
      endcase
      send_request(r);
    end else begin
      r = random_request();
      if ($urandom_range(0, 1) == 0) begin
        r.is_setup = 1'b1;
        r.req_type = 1'b0;
        r.request_code = 8'($urandom_range(0, 15));
        case ($urandom_range(0, 4))
          0: r.value_high = DESC_DEVICE;
          1: r.value_high = DESC_CONFIG;
          2: r.value_high = DESC_STRING;
          3: r.value_high = DESC_REPORT;
          default: ;
        endcase
      end
      send_request(r);
      return;
    end
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 1000;
    n = 0;
    while (tracker.transfer_open() && n < cut) begin
      send_request(in_done());
      n++;
    end
    if ($urandom_range(0, 3) == 0) send_request(in_done());
  endtask

  initial begin
    bit paused;
    tracker = new();
    counted_items = 0;
    hold_requests = 0;
    tx_gap_pct = 20;
    rx_stall_pct = 20;
    paused = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= 1'b0;
    is_setup <= 1'b0;
    request_bits <= '0;
    request_code <= '0;
    value_low <= '0;
    value_high <= '0;
    length_low <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    wait_idle();
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_phase(p);
      if (p == NUM_PHASES - 1) begin
        tx_gap_pct = 0;
        rx_stall_pct = 0;
      end else begin
        tx_gap_pct = $urandom_range(0, 40);
        rx_stall_pct = $urandom_range(0, 40);
      end
      // long receiver hold-off while requests keep coming
      if (p == 3) begin
        tx_gap_pct = 0;
        hold_requests++;
      end
      while (counted_items < (p + 1) * ITEMS_PER_PHASE) begin
        run_sequence();
        if (p == 5 && !paused && counted_items >= p * ITEMS_PER_PHASE + ITEMS_PER_PHASE / 2) begin
          wait_idle();
          paused = 1'b1;
        end
      end
      wait_idle();
    end
    repeat (10) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
